>>> src/lude_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lude_pkg: shared types and helpers for the LU element update block
// Item codes, sequencer states, status codes, the add/subtract unit request
// and the saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
package lude_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_TERM   = 2'd0,  // accumulate one product
    OP_FIN_U  = 2'd1,  // finish a U element
    OP_FIN_L  = 2'd2,  // finish an L element
    OP_START  = 2'd3   // only apply start_req, no result
  } lude_op_e;

  // Result status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_SAT        = 2'd1;
  localparam logic [1:0] STAT_PIVOT_ZERO = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIFF,
    ST_ROUND,
    ST_DMAG,
    ST_PMAG,
    ST_DIV,
    ST_SIGN,
    ST_OUT
  } lude_state_e;

  // Request to the shared add/subtract unit
  typedef struct packed {
    logic signed [64:0] a;
    logic signed [64:0] b;
    logic               sub;
  } lude_alu_req_t;

  // Saturated 32-bit value with clip flag
  typedef struct packed {
    logic signed [31:0] value;
    logic               sat;
  } lude_sat_t;

  // Clip a 65-bit signed sum to signed 64 bits
  function automatic logic [63:0] sat64(input logic [64:0] v);
    logic [63:0] r;
    if (v[64] != v[63]) begin
      r = v[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      r = v[63:0];
    end
    return r;
  endfunction

  // Clip a 65-bit signed value to signed 32 bits, flag when clipped
  function automatic lude_sat_t sat32(input logic [64:0] v);
    lude_sat_t r;
    if (v[64:31] == '0 || v[64:31] == '1) begin
      r.value = v[31:0];
      r.sat   = 1'b0;
    end else begin
      r.value = v[64] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
      r.sat   = 1'b1;
    end
    return r;
  endfunction

endpackage

>>> src/lude_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lude_in_if: input item channel
// Valid/ready channel carrying one term, finish or start-only item.
// ----------------------------------------------------------------------------
interface lude_in_if
  import lude_pkg::*;
();
  logic               valid;
  logic               ready;
  lude_op_e           op;
  logic               start_req;
  logic signed [31:0] a_value;
  logic signed [31:0] u_value;
  logic signed [31:0] l_value;
  logic signed [31:0] pivot;

  modport source (
    output valid, op, start_req, a_value, u_value, l_value, pivot,
    input  ready
  );

  modport sink (
    input  valid, op, start_req, a_value, u_value, l_value, pivot,
    output ready
  );
endinterface

>>> src/lude_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lude_out_if: result item channel
// Valid/ready channel carrying one computed L or U element.
// ----------------------------------------------------------------------------
interface lude_out_if ();
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;

  modport source (
    output valid, value, status,
    input  ready
  );

  modport sink (
    input  valid, value, status,
    output ready
  );
endinterface

>>> src/lude_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lude_mul: registered 32x32 signed multiplier
// Forms the exact product of a term pair and holds it for the accumulator.
// ----------------------------------------------------------------------------
module lude_mul (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] prod_o
);

  logic signed [63:0] prod_q;

  // Capture the exact product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 64'(a_i) * 64'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

>>> src/lude_addsub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lude_addsub: shared 65-bit add/subtract unit
// Serves accumulation, difference, rounding, negation and division steps.
// ----------------------------------------------------------------------------
module lude_addsub
  import lude_pkg::*;
(
  input  lude_alu_req_t      req_i,
  output logic signed [64:0] sum_o
);

  // Add or subtract the operands
  always_comb begin
    if (req_i.sub) begin
      sum_o = req_i.a - req_i.b;
    end else begin
      sum_o = req_i.a + req_i.b;
    end
  end

endmodule

>>> src/lu_element_dot_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_element_dot_update: Doolittle LU element update
// Accumulates U*L products and finishes one L or U element in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries term items (u_value, l_value) and finish items (a_value,
//   and pivot for an L element); start_req clears the accumulator first.
//   out_o returns one result item (value, status) per finish item.
//   All arithmetic runs through one 65-bit add/subtract unit under a
//   sequencer, plus a registered multiplier for the term products.
// Sequencing:
//   A new item is accepted only while the sequencer is idle, so the block
//   works on one item at a time. A start-only item (op 3) leaves the
//   sequencer idle. The L finish cost is the 64 restoring division steps on
//   the shared unit.
// Reset clears the accumulator, the sequencer and the output valid.
// A finished result waits in the output register; while the receiver
// stalls and the register is full, the sequencer holds the next result and
// accepts no new item until the register frees up.
// ----------------------------------------------------------------------------
module lu_element_dot_update
  import lude_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lude_in_if.sink     in_i,
  lude_out_if.source  out_o
);

  lude_state_e        state_q, state_d;
  lude_op_e           op_q;
  logic signed [31:0] a_q, u_q, l_q, pivot_q;
  logic [63:0]        acc_q;
  logic [63:0]        diff_q;
  logic [63:0]        dq_q;
  logic [31:0]        rem_q;
  logic [31:0]        pmag_q;
  logic               neg_q;
  logic [5:0]         cnt_q;
  logic signed [31:0] res_value_q;
  logic [1:0]         res_status_q;
  logic               out_valid_q;
  logic signed [31:0] out_value_q;
  logic [1:0]         out_status_q;

  logic               in_accept;
  logic               load_out;
  logic signed [63:0] prod;
  logic [63:0]        a_shift;
  logic [63:0]        diff_shift;
  logic               qbit;
  lude_alu_req_t      alu_req;
  logic signed [64:0] alu_sum;
  lude_sat_t          sat_res;

  assign in_accept  = in_i.valid && in_i.ready;
  assign load_out   = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);
  assign a_shift    = {{(32 - FRAC_BITS){a_q[31]}}, a_q, {FRAC_BITS{1'b0}}};
  assign diff_shift = $signed(diff_q) >>> FRAC_BITS;
  assign qbit       = ~alu_sum[64];
  assign sat_res    = sat32(alu_sum);

  lude_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (state_q == ST_MUL),
    .a_i    (u_q),
    .b_i    (l_q),
    .prod_o (prod)
  );

  lude_addsub u_addsub (
    .req_i (alu_req),
    .sum_o (alu_sum)
  );

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state, handshake and shared unit operands
  always_comb begin
    state_d     = state_q;
    in_i.ready  = 1'b0;
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          case (in_i.op)
            OP_TERM:  state_d = ST_MUL;
            OP_FIN_U: state_d = ST_DIFF;
            OP_FIN_L: state_d = ST_DIFF;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_MUL: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        alu_req.a = {acc_q[63], acc_q};
        alu_req.b = {prod[63], prod};
        state_d   = ST_IDLE;
      end
      ST_DIFF: begin
        alu_req.a   = {a_shift[63], a_shift};
        alu_req.b   = {acc_q[63], acc_q};
        alu_req.sub = 1'b1;
        if (op_q == OP_FIN_U) begin
          state_d = ST_ROUND;
        end else if (pivot_q == '0) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_DMAG;
        end
      end
      ST_ROUND: begin
        alu_req.a = {diff_shift[63], diff_shift};
        alu_req.b = {64'b0, diff_q[FRAC_BITS-1]};
        state_d   = ST_OUT;
      end
      ST_DMAG: begin
        alu_req.b   = {diff_q[63], diff_q};
        alu_req.sub = 1'b1;
        state_d     = ST_PMAG;
      end
      ST_PMAG: begin
        alu_req.b   = {{33{pivot_q[31]}}, pivot_q};
        alu_req.sub = 1'b1;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        alu_req.a   = {32'b0, rem_q, dq_q[63]};
        alu_req.b   = {33'b0, pmag_q};
        alu_req.sub = 1'b1;
        if (cnt_q == '1) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        alu_req.b   = {1'b0, dq_q};
        alu_req.sub = neg_q;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Accumulator and divider step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else begin
      if (in_accept && in_i.start_req) begin
        acc_q <= '0;
      end else if (state_q == ST_ACC) begin
        acc_q <= sat64(alu_sum);
      end
      if (state_q == ST_PMAG) begin
        cnt_q <= '0;
      end else if (state_q == ST_DIV) begin
        cnt_q <= cnt_q + 6'd1;
      end
    end
  end

  // Capture the item and advance the datapath
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= in_i.op;
      a_q     <= in_i.a_value;
      u_q     <= in_i.u_value;
      l_q     <= in_i.l_value;
      pivot_q <= in_i.pivot;
    end
    case (state_q)
      ST_DIFF: begin
        diff_q       <= sat64(alu_sum);
        res_value_q  <= '0;
        res_status_q <= STAT_PIVOT_ZERO;
      end
      ST_ROUND, ST_SIGN: begin
        res_value_q  <= sat_res.value;
        res_status_q <= sat_res.sat ? STAT_SAT : STAT_OK;
      end
      ST_DMAG: begin
        dq_q  <= diff_q[63] ? alu_sum[63:0] : diff_q;
        neg_q <= diff_q[63] ^ pivot_q[31];
        rem_q <= '0;
      end
      ST_PMAG: begin
        pmag_q <= pivot_q[31] ? alu_sum[31:0] : pivot_q;
      end
      ST_DIV: begin
        rem_q <= qbit ? alu_sum[31:0] : {rem_q[30:0], dq_q[63]};
        dq_q  <= {dq_q[62:0], qbit};
      end
      default: begin
      end
    endcase
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.value  = out_value_q;
  assign out_o.status = out_status_q;

  // Checks
  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result valid rose without a finished element");

  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_i.op != OP_START) |=> state_q != ST_IDLE)
    else $error("sequencer idle right after a working item");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == '1) |=> state_q == ST_SIGN)
    else $error("divider did not finish after the last step");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < pmag_q)
    else $error("division remainder not below divisor");

  a_pivot_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && res_status_q == STAT_PIVOT_ZERO) |-> res_value_q == '0)
    else $error("zero pivot result carries a nonzero value");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the LU element update block
// Walks a short table of edge-case items (empty sums, saturated sums, zero
// pivots, rounding ties, field extremes), then random sequences: mostly a
// start, a few term pairs and a U or L finish, else noise items or sums with no
// start. Both channels idle at random. Each finish item is predicted; each
// returned element is compared field by field to the oldest pending one.
// ----------------------------------------------------------------------------
module tb_top;
  import lude_pkg::*;

  localparam int FRAC_BITS    = 16;
  localparam int ITEM_TARGET  = 1450;
  localparam int PAUSE_EVERY  = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 800_000;
  localparam int MAX_REPORTS  = 10;

  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [63:0]        QUO_CAP = 64'd1 << 40;

  typedef struct {
    lude_op_e           op;
    logic               start;
    logic signed [31:0] a_value;
    logic signed [31:0] u_value;
    logic signed [31:0] l_value;
    logic signed [31:0] pivot;
  } lu_item_t;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         status;
  } lu_elem_t;

  // One row of the directed table; typed marks a hand-written expectation
  typedef struct {
    lude_op_e           op;
    logic               start;
    logic signed [31:0] a_value;
    logic signed [31:0] u_value;
    logic signed [31:0] l_value;
    logic signed [31:0] pivot;
    bit                 typed;
    logic signed [31:0] value;
    logic [1:0]         status;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  lude_in_if  in_if ();
  lude_out_if out_if ();

  lu_element_dot_update #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  logic signed [63:0] dot_acc;
  lu_elem_t           elements_due[$];
  dir_row_t           dir_rows[$];
  int unsigned        mismatches = 0;
  int unsigned        items_sent;
  int unsigned        cycle_cnt = 0;
  bit                 send_calm;

  // Free-running clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Clip a 65-bit sum to the 64-bit accumulator range
  function automatic logic signed [63:0] clip_acc(input logic signed [64:0] v);
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    hi = ACC_MAX;
    lo = ACC_MIN;
    if (v > hi) return ACC_MAX;
    if (v < lo) return ACC_MIN;
    return v[63:0];
  endfunction

  // Clip a quotient to Q16.16 and set the status
  function automatic lu_elem_t clip_elem(input logic signed [63:0] q);
    lu_elem_t           r;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = Q_MAX;
    lo = Q_MIN;
    r.status = STAT_OK;
    if (q > hi) begin
      r.value  = Q_MAX;
      r.status = STAT_SAT;
    end else if (q < lo) begin
      r.value  = Q_MIN;
      r.status = STAT_SAT;
    end else begin
      r.value = q[31:0];
    end
    return r;
  endfunction

  // Advance the dot-product state by one item and compute its element
  task automatic predict_element(input lu_item_t it, output bit has_elem,
                                 output lu_elem_t elem);
    logic signed [63:0] prod;
    logic signed [63:0] a_scaled;
    logic signed [63:0] diff;
    logic signed [63:0] q;
    logic signed [63:0] pv;
    logic signed [64:0] wide;
    logic [63:0]        dmag;
    logic [63:0]        pmag;
    logic [63:0]        qmag;
    has_elem = 1'b0;
    elem     = '{32'sd0, STAT_OK};
    if (it.start) dot_acc = '0;
    if (it.op == OP_TERM) begin
      prod    = it.u_value * it.l_value;
      wide    = dot_acc + prod;
      dot_acc = clip_acc(wide);
    end else if (it.op != OP_START) begin
      has_elem = 1'b1;
      a_scaled = it.a_value;
      a_scaled = a_scaled <<< FRAC_BITS;
      wide     = a_scaled - dot_acc;
      diff     = clip_acc(wide);
      if (it.op == OP_FIN_U) begin
        // round to nearest, ties up
        q = diff >>> FRAC_BITS;
        if (diff[FRAC_BITS-1]) q = q + 1;
        elem = clip_elem(q);
      end else if (it.pivot == 0) begin
        elem = '{32'sd0, STAT_PIVOT_ZERO};
      end else begin
        // divide magnitudes, truncate toward zero
        pv   = it.pivot;
        dmag = diff;
        if (diff < 0) dmag = -dmag;
        pmag = pv;
        if (pv < 0) pmag = -pmag;
        qmag = dmag / pmag;
        if (qmag > QUO_CAP) qmag = QUO_CAP;
        q = qmag;
        if ((diff < 0) != (pv < 0)) q = -q;
        elem = clip_elem(q);
      end
    end
  endtask

  // Count a mismatch, report the first few
  task automatic flag_mismatch(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, what, want_v, got_v);
    end
  endtask

  // Q16.16 value, mostly small when tame
  function automatic logic signed [31:0] draw_fixed(input bit tame);
    logic signed [31:0] v;
    if (tame && $urandom_range(0, 9) < 7) begin
      v = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: v = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        3, 4:    v = $urandom();
        5:       v = Q_MAX;
        6:       v = Q_MIN;
        7:       v = '0;
        default: begin
          v = $urandom_range(1, 4) << FRAC_BITS;
          if ($urandom_range(0, 1)) v = -v;
        end
      endcase
    end
    return v;
  endfunction

  function automatic lu_item_t term_item(input bit start);
    lu_item_t it;
    it.op      = OP_TERM;
    it.start   = start;
    it.a_value = $urandom();
    it.u_value = draw_fixed(1'b1);
    it.l_value = draw_fixed(1'b1);
    it.pivot   = $urandom();
    return it;
  endfunction

  function automatic lu_item_t finish_item(input bit start);
    lu_item_t it;
    it.op      = $urandom_range(0, 1) ? OP_FIN_U : OP_FIN_L;
    it.start   = start;
    it.a_value = draw_fixed(1'b1);
    it.u_value = $urandom();
    it.l_value = $urandom();
    case ($urandom_range(0, 7))
      0:       it.pivot = '0;
      1:       it.pivot = $urandom();
      default: it.pivot = draw_fixed(1'b1);
    endcase
    return it;
  endfunction

  // Send one item after a random gap; predict it once accepted
  task automatic drive_item(input lu_item_t it, input bit typed,
                            input lu_elem_t typed_elem);
    int unsigned gap;
    bit          has_elem;
    lu_elem_t    elem;
    gap = send_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.op        <= it.op;
    in_if.start_req <= it.start;
    in_if.a_value   <= it.a_value;
    in_if.u_value   <= it.u_value;
    in_if.l_value   <= it.l_value;
    in_if.pivot     <= it.pivot;
    do @(negedge clk_i); while (in_if.ready !== 1'b1);
    @(posedge clk_i);
    items_sent++;
    predict_element(it, has_elem, elem);
    if (has_elem) elements_due.push_back(typed ? typed_elem : elem);
  endtask

  // Hold off until every pending element has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (elements_due.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random ready gaps, compare in order
  initial begin : result_sink
    lu_elem_t           want;
    logic signed [31:0] got_value;
    logic [1:0]         got_status;
    int unsigned        gap;
    bit                 calm;
    calm = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 19) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(negedge clk_i); while (out_if.valid !== 1'b1);
      got_value  = out_if.value;
      got_status = out_if.status;
      @(posedge clk_i);
      if (elements_due.size() == 0) begin
        flag_mismatch("unexpected element", '0, got_value);
      end else begin
        want = elements_due.pop_front();
        if (got_value !== want.value) flag_mismatch("value", want.value, got_value);
        if (got_status !== want.status) begin
          flag_mismatch("status", 32'(want.status), 32'(got_status));
        end
      end
    end
  end

  // Stimulus
  initial begin : item_source
    lu_item_t    it;
    lu_elem_t    typed_elem;
    lu_elem_t    no_elem;
    int unsigned shape;
    int unsigned n_terms;
    int unsigned next_pause;

    in_if.valid     <= 1'b0;
    in_if.op        <= OP_TERM;
    in_if.start_req <= 1'b0;
    in_if.a_value   <= '0;
    in_if.u_value   <= '0;
    in_if.l_value   <= '0;
    in_if.pivot     <= '0;
    rst_ni          <= 1'b0;
    dot_acc    = '0;
    items_sent = 0;
    send_calm  = 1'b0;
    no_elem    = '{32'sd0, STAT_OK};

    // Directed table: op, start, a, u, l, pivot, typed, value, status
    // empty sums and extremes of a
    dir_rows.push_back('{OP_FIN_U, 1'b0, Q_ONE, 0, 0, 0, 1'b1, Q_ONE, STAT_OK});
    dir_rows.push_back('{OP_FIN_U, 1'b1, Q_MAX, 0, 0, 0, 1'b1, Q_MAX, STAT_OK});
    dir_rows.push_back('{OP_FIN_U, 1'b0, Q_MIN, 0, 0, 0, 1'b1, Q_MIN, STAT_OK});
    // zero pivot, unit pivot, clipped quotients
    dir_rows.push_back('{OP_FIN_L, 1'b0, 32'sh1234_5678, 0, 0, 0, 1'b1, 0,
                         STAT_PIVOT_ZERO});
    dir_rows.push_back('{OP_FIN_L, 1'b1, Q_ONE, 0, 0, Q_ONE, 1'b1, Q_ONE, STAT_OK});
    dir_rows.push_back('{OP_FIN_L, 1'b0, Q_ONE, 0, 0, 1, 1'b1, Q_MAX, STAT_SAT});
    dir_rows.push_back('{OP_FIN_L, 1'b0, Q_MIN, 0, 0, 1, 1'b1, Q_MIN, STAT_SAT});
    dir_rows.push_back('{OP_FIN_L, 1'b0, Q_MAX, 0, 0, Q_MIN, 1'b0, 0, STAT_OK});
    // drive the sum into positive saturation
    dir_rows.push_back('{OP_TERM, 1'b1, 0, Q_MAX, Q_MAX, 0, 1'b0, 0, STAT_OK});
    dir_rows.push_back('{OP_TERM, 1'b0, 0, Q_MAX, Q_MAX, 0, 1'b0, 0, STAT_OK});
    dir_rows.push_back('{OP_TERM, 1'b0, 0, Q_MIN, Q_MIN, 0, 1'b0, 0, STAT_OK});
    dir_rows.push_back('{OP_FIN_U, 1'b0, 0, 0, 0, 0, 1'b1, Q_MIN, STAT_SAT});
    dir_rows.push_back('{OP_FIN_L, 1'b0, 0, 0, 0, Q_MIN, 1'b1, Q_MAX, STAT_SAT});
    // drive the sum into negative saturation
    dir_rows.push_back('{OP_TERM, 1'b1, 0, Q_MIN, Q_MAX, 0, 1'b0, 0, STAT_OK});
    dir_rows.push_back('{OP_TERM, 1'b0, 0, Q_MIN, Q_MAX, 0, 1'b0, 0, STAT_OK});
    dir_rows.push_back('{OP_TERM, 1'b0, 0, Q_MIN, Q_MAX, 0, 1'b0, 0, STAT_OK});
    dir_rows.push_back('{OP_FIN_U, 1'b0, Q_MAX, 0, 0, 0, 1'b1, Q_MAX, STAT_SAT});
    // start-only item clears the sum
    dir_rows.push_back('{OP_START, 1'b1, 0, 0, 0, 0, 1'b0, 0, STAT_OK});
    dir_rows.push_back('{OP_FIN_U, 1'b0, -32'sd1, 0, 0, 0, 1'b1, -32'sd1, STAT_OK});
    // rounding ties on either side of zero
    dir_rows.push_back('{OP_TERM, 1'b1, 0, 1, 32'sh0000_8000, 0, 1'b0, 0, STAT_OK});
    dir_rows.push_back('{OP_FIN_U, 1'b0, 0, 0, 0, 0, 1'b0, 0, STAT_OK});
    dir_rows.push_back('{OP_TERM, 1'b0, 0, -32'sd1, Q_ONE, 0, 1'b0, 0, STAT_OK});
    dir_rows.push_back('{OP_FIN_U, 1'b0, 0, 0, 0, 0, 1'b0, 0, STAT_OK});
    // start-only item without start keeps the sum
    dir_rows.push_back('{OP_START, 1'b0, 0, 0, 0, 0, 1'b0, 0, STAT_OK});
    dir_rows.push_back('{OP_FIN_L, 1'b0, 32'sh0003_0000, 0, 0, -32'sh0002_0000,
                         1'b0, 0, STAT_OK});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      it.op      = dir_rows[i].op;
      it.start   = dir_rows[i].start;
      it.a_value = dir_rows[i].a_value;
      it.u_value = dir_rows[i].u_value;
      it.l_value = dir_rows[i].l_value;
      it.pivot   = dir_rows[i].pivot;
      typed_elem = '{dir_rows[i].value, dir_rows[i].status};
      drive_item(it, dir_rows[i].typed, typed_elem);
    end
    drain_results();

    // Random sequences
    next_pause = items_sent + PAUSE_EVERY;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_pause) begin
        drain_results();
        next_pause = items_sent + PAUSE_EVERY;
      end
      send_calm = ($urandom_range(0, 3) == 0);
      shape     = $urandom_range(0, 9);
      if (shape <= 7) begin
        // well-formed: start, terms, one finish, sometimes a second on the same sum
        n_terms = $urandom_range(0, 6);
        for (int unsigned k = 0; k < n_terms; k++) begin
          drive_item(term_item(k == 0), 1'b0, no_elem);
        end
        drive_item(finish_item(n_terms == 0), 1'b0, no_elem);
        if ($urandom_range(0, 3) == 0) drive_item(finish_item(1'b0), 1'b0, no_elem);
      end else if (shape == 8) begin
        // noise: any op, any start, full-range fields
        repeat ($urandom_range(1, 4)) begin
          it.op      = lude_op_e'($urandom_range(0, 3));
          it.start   = $urandom_range(0, 1);
          it.a_value = $urandom();
          it.u_value = $urandom();
          it.l_value = $urandom();
          it.pivot   = $urandom();
          drive_item(it, 1'b0, no_elem);
        end
      end else begin
        // broken: no start, terms pile onto the old sum
        repeat ($urandom_range(1, 3)) drive_item(term_item(1'b0), 1'b0, no_elem);
        drive_item(finish_item(1'b0), 1'b0, no_elem);
      end
    end

    // Drain and settle
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
src/lude_pkg.sv
src/lude_in_if.sv
src/lude_out_if.sv
src/lude_mul.sv
src/lude_addsub.sv
src/lu_element_dot_update.sv
dv/tb_top.sv
